/* hdl/assert_macros.svh */
// Concurrent assertion helpers, active in simulation only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/bfsp_pkg.sv */
package bfsp_pkg;

  localparam int MAX_SHELVES_DEFAULT = 256;
  localparam int CFG_INDEX_W = 8;
  localparam int DIM_W = 16;
  localparam int Y_W = 24;

  localparam logic [DIM_W-1:0] STRIP_WIDTH_RESET = 16'd1024;

  localparam logic [CFG_INDEX_W-1:0] REG_STRIP_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATE_TALL = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [Y_W-1:0]   base;
    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] fill;
  } shelf_t;

endpackage

/* hdl/bfsp_ram.sv */
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/best_fit_shelf_packer_unit.sv */
// An item is accepted only in the idle state; the unit then sweeps the open shelves,
// picks the best fit and registers the result, and takes no new item until that
// result is registered. The single read port of the shelf table is swept once per
// item, one shelf per cycle (up to MAX_SHELVES); the shelf count is taken after an
// optional clear by start_job. A pending result is held in the output register
// while the next item scans.
// Reset clears the shelf count, the ceiling and the handshakes and restores the
// register defaults; the shelf table itself is not cleared.
`include "assert_macros.svh"

module best_fit_shelf_packer_unit import bfsp_pkg::*; #(
  parameter int MAX_SHELVES = MAX_SHELVES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // rect_width, rect_height
  input  logic [0:0]             s_tuser,   // start_job
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [95:0]            m_tdata,   // pos_x, pos_y, placed_width, placed_height,
                                            // strip_height
  output logic [1:0]             m_tuser,   // opened_shelf, overflow
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CW = $clog2(MAX_SHELVES + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_SHELVES);
  localparam int WIDTH_RD = $bits(shelf_t);

  state_t state, state_next;

  logic [DIM_W-1:0] strip_width;
  logic             rotate_tall;
  logic [CW-1:0]    count;
  logic [Y_W-1:0]   ceiling;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [CW-1:0]    issue_idx;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx;
  logic             found;
  logic [AW-1:0]    best_idx;
  logic [DIM_W-1:0] best_fill;
  logic [Y_W-1:0]   best_base;

  logic             in_acc;
  logic             issuing;
  logic             out_free;
  logic             finish;
  logic [DIM_W-1:0] in_w;
  logic [DIM_W-1:0] in_h;
  logic             swap;
  shelf_t           rd_shelf;
  logic [WIDTH_RD-1:0] rd_raw;
  logic             fits;
  logic             take;
  logic [Y_W:0]     ceil_sum;
  logic             ovf;
  logic             opened;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  shelf_t           ram_wdata;
  logic [DIM_W-1:0] res_x;
  logic [Y_W-1:0]   res_y;
  logic [Y_W-1:0]   res_ceil;

  bfsp_ram #(
    .WIDTH (WIDTH_RD),
    .DEPTH (MAX_SHELVES)
  ) u_shelves (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_raw)
  );

  assign rd_shelf  = shelf_t'(rd_raw);
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign issuing   = (state == ST_SCAN) && (issue_idx < count);
  assign finish    = (state == ST_FINISH) && out_free;

  assign in_w = s_tdata[15:0];
  assign in_h = s_tdata[31:16];
  assign swap = rotate_tall && (in_w < in_h);

  assign fits = (rd_shelf.room >= h) &&
                (({1'b0, rd_shelf.fill} + {1'b0, w}) <= {1'b0, strip_width});
  assign take = rd_pend && fits && (!found || (rd_shelf.fill > best_fill));

  assign ceil_sum = {1'b0, ceiling} + {{(Y_W + 1 - DIM_W){1'b0}}, h};
  assign ovf      = !found && ((count == COUNT_FULL) || ceil_sum[Y_W]);
  assign opened   = !found && !ovf;

  always_comb begin
    ram_we    = finish && !ovf;
    ram_waddr = found ? best_idx : count[AW-1:0];
    ram_wdata.room = h;
    if (found) begin
      ram_wdata.base = best_base;
      ram_wdata.fill = best_fill + w;
      res_x          = best_fill;
      res_y          = best_base;
      res_ceil       = ceiling;
    end else if (ovf) begin
      ram_wdata.base = ceiling;
      ram_wdata.fill = w;
      res_x          = '0;
      res_y          = '0;
      res_ceil       = ceiling;
    end else begin
      ram_wdata.base = ceiling;
      ram_wdata.fill = w;
      res_x          = '0;
      res_y          = ceiling;
      res_ceil       = ceil_sum[Y_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issuing && !rd_pend) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_width <= STRIP_WIDTH_RESET;
      rotate_tall <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STRIP_WIDTH) strip_width <= cfg_data;
      if (cfg_index == REG_ROTATE_TALL) rotate_tall <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ceiling <= '0;
    end else if (in_acc && s_tuser[0]) begin
      count   <= '0;
      ceiling <= '0;
    end else if (finish && opened) begin
      count   <= count + CW'(1);
      ceiling <= ceil_sum[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      w <= swap ? in_h : in_w;
      h <= swap ? in_w : in_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      issue_idx <= '0;
    end else begin
      rd_pend <= issuing;
      if (in_acc) begin
        found     <= 1'b0;
        issue_idx <= '0;
      end else begin
        if (issuing) issue_idx <= issue_idx + CW'(1);
        if (take) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_idx[AW-1:0];
    if (take) begin
      best_idx  <= rd_idx;
      best_fill <= rd_shelf.fill;
      best_base <= rd_shelf.base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {res_ceil, h, w, res_y, res_x};
      m_tuser <= {ovf, opened};
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= COUNT_FULL)
  `ASSERT_IMPLY(a_open_counts, clk, rst, finish && opened, count == $past(count) + CW'(1))
  `ASSERT_ALWAYS(a_no_write_in_scan, clk, rst, !(ram_we && (issuing || rd_pend)))

endmodule

/* tb/sv/shelf_packing_checker.sv */
`timescale 1ns / 100ps

module shelf_packing_checker import bfsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [31:0]            s_tdata,   // rect_width, rect_height
  input  logic [0:0]             s_tuser,   // start_job
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [95:0]            m_tdata,   // pos_x, pos_y, placed_width, placed_height,
                                            // strip_height
  input  logic [1:0]             m_tuser,   // opened_shelf, overflow
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    logic [DIM_W-1:0] pos_x;
    logic [Y_W-1:0]   pos_y;
    logic [DIM_W-1:0] placed_width;
    logic [DIM_W-1:0] placed_height;
    logic [Y_W-1:0]   strip_height;
    logic             opened_shelf;
    logic             overflow;
  } placement_t;

  logic [Y_W-1:0]   base_y [MAX_SHELVES_DEFAULT];
  logic [DIM_W-1:0] room_h [MAX_SHELVES_DEFAULT];
  logic [DIM_W-1:0] fill_x [MAX_SHELVES_DEFAULT];
  int unsigned      used_shelves;
  logic [Y_W-1:0]   top_y;
  logic [DIM_W-1:0] width_limit;
  logic             turn_tall;

  placement_t placements_due[$];

  function automatic placement_t place_rect(input logic start, input logic [DIM_W-1:0] w_in,
                                            input logic [DIM_W-1:0] h_in);
    placement_t       r;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int unsigned      best;
    bit               found;
    w = w_in;
    h = h_in;
    if (start) begin
      used_shelves = 0;
      top_y = '0;
    end
    if (turn_tall && w_in < h_in) begin
      w = h_in;
      h = w_in;
    end
    found = 1'b0;
    best = 0;
    for (int j = 0; j < used_shelves; j++) begin
      if (room_h[j] >= h && {1'b0, fill_x[j]} + {1'b0, w} <= {1'b0, width_limit}) begin
        if (!found || fill_x[j] > fill_x[best]) begin
          best = j;
          found = 1'b1;
        end
      end
    end
    r = '0;
    r.placed_width = w;
    r.placed_height = h;
    if (found) begin
      r.pos_x = fill_x[best];
      r.pos_y = base_y[best];
      room_h[best] = h;
      fill_x[best] = fill_x[best] + w;
    end else if (used_shelves >= MAX_SHELVES_DEFAULT ||
                 {1'b0, top_y} + {9'd0, h} > {1'b0, {Y_W{1'b1}}}) begin
      r.overflow = 1'b1;
    end else begin
      r.pos_y = top_y;
      base_y[used_shelves] = top_y;
      room_h[used_shelves] = h;
      fill_x[used_shelves] = w;
      used_shelves++;
      top_y = top_y + h;
      r.opened_shelf = 1'b1;
    end
    r.strip_height = top_y;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [Y_W-1:0] got,
                                 input logic [Y_W-1:0] want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (rst) begin
      used_shelves = 0;
      top_y = '0;
      width_limit = STRIP_WIDTH_RESET;
      turn_tall = 1'b0;
      placements_due.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STRIP_WIDTH: width_limit = cfg_data;
          REG_ROTATE_TALL: turn_tall = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        placements_due.insert(placements_due.size(),
                              place_rect(s_tuser[0], s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        got.pos_x = m_tdata[15:0];
        got.pos_y = m_tdata[39:16];
        got.placed_width = m_tdata[55:40];
        got.placed_height = m_tdata[71:56];
        got.strip_height = m_tdata[95:72];
        got.opened_shelf = m_tuser[0];
        got.overflow = m_tuser[1];
        if (placements_due.size() == 0) begin
          report_mismatch("unexpected item", got.pos_y, '0);
        end else begin
          want = placements_due.pop_front();
          if (got.pos_x !== want.pos_x)
            report_mismatch("pos_x", Y_W'(got.pos_x), Y_W'(want.pos_x));
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.placed_width !== want.placed_width)
            report_mismatch("placed_width", Y_W'(got.placed_width), Y_W'(want.placed_width));
          if (got.placed_height !== want.placed_height)
            report_mismatch("placed_height", Y_W'(got.placed_height),
                            Y_W'(want.placed_height));
          if (got.strip_height !== want.strip_height)
            report_mismatch("strip_height", got.strip_height, want.strip_height);
          if (got.opened_shelf !== want.opened_shelf)
            report_mismatch("opened_shelf", Y_W'(got.opened_shelf), Y_W'(want.opened_shelf));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", Y_W'(got.overflow), Y_W'(want.overflow));
        end
      end
      outstanding <= placements_due.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bfsp_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [31:0]            s_tdata;   // rect_width, rect_height
  logic [0:0]             s_tuser;   // start_job
  logic                   m_tvalid;
  logic                   m_tready;
  logic [95:0]            m_tdata;   // pos_x, pos_y, placed_width, placed_height, strip_height
  logic [1:0]             m_tuser;   // opened_shelf, overflow
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DIM_W-1:0]       cfg_data;
  int                     fail_count;
  int                     outstanding;

  int unsigned burst_left;
  bit          gaps_on;

  best_fit_shelf_packer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  shelf_packing_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: stall pattern changes per stretch, with long counted hold-offs
  initial begin
    int unsigned cyc;
    int unsigned stretch;
    rx_mode_t    mode;
    m_tready <= 1'b0;
    cyc = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(20, 400);
      repeat (stretch) begin
        @(posedge clk);
        cyc++;
        if (cyc % 60000 == 30000) begin
          m_tready <= 1'b0;
          repeat (4000) @(posedge clk);
          cyc += 4000;
        end
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
          default:   m_tready <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  task automatic send_rect(input logic start, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= start;
    s_tdata <= {h, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // jobs of decreasing heights with random widths, plus some out-of-order noise
  task automatic run_jobs(input int unsigned n_items, input logic [DIM_W-1:0] strip);
    int unsigned      sent;
    int unsigned      len;
    int unsigned      wmax;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] hi;
    logic [DIM_W-1:0] w;
    bit               fresh;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 80);
      gaps_on = ($urandom_range(0, 4) != 0);
      h = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(1, 65535))
                                      : DIM_W'($urandom_range(1, 2000));
      wmax = (strip < 8) ? 8 : strip / $urandom_range(1, 8);
      fresh = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < len && sent < n_items; i++) begin
        if ($urandom_range(0, 9) == 0)
          w = DIM_W'($urandom_range(0, 65535));
        else
          w = DIM_W'($urandom_range(1, wmax));
        hi = ($urandom_range(0, 19) == 0) ? DIM_W'($urandom_range(0, 65535)) : h;
        send_rect(fresh && i == 0, w, hi);
        if (h > 1) h = h - DIM_W'($urandom_range(0, h / 8));
        sent++;
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end
  endtask

  initial begin
    logic [DIM_W-1:0] hh;
    logic [DIM_W-1:0] strip;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_STRIP_WIDTH;
    cfg_data <= '0;
    burst_left = 0;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_rect(1'b0, 16'd100, 16'd65535);
    send_rect(1'b1, 16'd65535, 16'd65535);
    send_rect(1'b0, 16'd500, 16'd60000);
    send_rect(1'b0, 16'd524, 16'd50000);
    send_rect(1'b0, 16'd1, 16'd1);
    send_rect(1'b0, 16'd1023, 16'd1);
    send_rect(1'b0, 16'd0, 16'd0);
    send_rect(1'b0, 16'd10, 16'd0);
    send_rect(1'b0, 16'd0, 16'd5);
    send_rect(1'b1, 16'd300, 16'd1000);
    send_rect(1'b0, 16'd200, 16'd900);
    send_rect(1'b0, 16'd100, 16'd2000);
    send_rect(1'b0, 16'd50, 16'd800);
    send_rect(1'b0, 16'd600, 16'd100);
    drain_results();

    write_reg(REG_STRIP_WIDTH, 16'hFFFF);
    write_reg(REG_ROTATE_TALL, 16'd1);
    send_rect(1'b1, 16'd1, 16'd65535);
    send_rect(1'b0, 16'd65535, 16'd1);
    send_rect(1'b0, 16'd7, 16'd7);
    send_rect(1'b0, 16'd3, 16'd9);
    send_rect(1'b0, 16'hAAAA, 16'h5555);
    drain_results();

    // fill the shelf table one shelf per item, then overflow, then clear
    write_reg(REG_STRIP_WIDTH, 16'd1);
    write_reg(REG_ROTATE_TALL, 16'd0);
    hh = 16'hFFFF;
    send_rect(1'b1, 16'd1, hh);
    repeat (258) begin
      if (hh > 300) hh = hh - DIM_W'($urandom_range(0, 255));
      send_rect(1'b0, 16'd1, hh);
    end
    send_rect(1'b1, 16'd1, 16'd40);
    drain_results();

    write_reg(REG_STRIP_WIDTH, 16'd0);
    send_rect(1'b1, 16'd5, 16'd5);
    send_rect(1'b0, 16'd3, 16'd3);
    send_rect(1'b0, 16'd0, 16'd2);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: strip = 16'hFFFF;
        1: strip = DIM_W'($urandom_range(1, 64));
        2: strip = 16'd1024;
        3: strip = DIM_W'($urandom_range(1, 65535));
        4: strip = DIM_W'($urandom_range(100, 5000));
        default: strip = 16'hFFFF;
      endcase
      write_reg(REG_STRIP_WIDTH, strip);
      write_reg(REG_ROTATE_TALL, DIM_W'(p % 2));
      run_jobs(220, strip);
      drain_results();
    end

    repeat (260) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* best_fit_shelf_packer_unit.f */
+incdir+hdl
hdl/bfsp_pkg.sv
hdl/bfsp_ram.sv
hdl/best_fit_shelf_packer_unit.sv
tb/sv/shelf_packing_checker.sv
tb/sv/tb_top.sv
